// ===== hdl/insertion_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// insertion_sorter_defines
// assertion macros shared by the insertion sorter checkers
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISORT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("insertion sorter check failed");

// next-cycle implication, sampled on clk, off during reset
`define ISORT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("insertion sorter check failed");

`endif

// ===== hdl/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg
// types and constants of the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int MAX_ITEMS_DEF = 16;
  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } isort_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } isort_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } isort_ctl_t;

endpackage

// ===== hdl/isort_cell.sv =====
// ----------------------------------------------------------------------------
// isort_cell
// one compare-and-shift slot of the sorting chain
// ----------------------------------------------------------------------------
module isort_cell
  import isort_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  isort_ctl_t                ctl,
  input  logic signed [VALUE_W-1:0] new_value,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic                      left_occ,
  input  logic                      left_disp,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic                      right_occ,
  output logic signed [VALUE_W-1:0] value,
  output logic                      occ,
  output logic                      disp
);

  // a slot moves right when it is empty or holds something strictly greater
  assign disp = !occ || (value > new_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.shift) begin
      occ <= right_occ;
    end else if (ctl.insert && disp) begin
      occ <= left_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value <= right_value;
    end else if (ctl.insert && disp) begin
      // first displaced slot takes the new value, the rest take the left slot
      value <= left_disp ? left_value : new_value;
    end
  end

endmodule

// ===== hdl/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter
// stable ascending sort of one block of signed values in a chain of cells
// ----------------------------------------------------------------------------
// Values are taken one per cycle while a block loads: every cell compares the
// incoming value against its own entry at once, and the entries above the
// insertion point move one cell along. Once the value marked is_last is
// taken, input stalls and the chain shifts toward cell 0, handing out one
// sorted result per cycle while the result side does not stall. Loading of
// the next block starts the cycle after the final result is taken. Values
// beyond MAX_ITEMS are dropped and every result of that block carries
// overflow. No clearing pass is needed after reset.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  isort_in_t  item,
  output logic       result_valid,
  input  logic       result_stall,
  output isort_out_t result
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic       state;
  logic       state_next;
  logic       dropped;
  logic       dropped_next;
  isort_ctl_t ctl;
  logic       take_item;
  logic       full;
  logic       drain_done;

  logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]      cell_occ;
  logic [MAX_ITEMS-1:0]      cell_disp;
  logic [MAX_ITEMS-1:0]      right_occ;

  genvar g;
  generate
    for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
      logic signed [VALUE_W-1:0] lv;
      logic                      lo;
      logic                      ld;
      logic signed [VALUE_W-1:0] rv;

      if (g == 0) begin : g_head
        assign lv = item.value;
        assign lo = 1'b1;
        assign ld = 1'b0;
      end else begin : g_mid
        assign lv = cell_value[g-1];
        assign lo = cell_occ[g-1];
        assign ld = cell_disp[g-1];
      end

      if (g == MAX_ITEMS - 1) begin : g_tail
        assign rv           = item.value;
        assign right_occ[g] = 1'b0;
      end else begin : g_body
        assign rv           = cell_value[g+1];
        assign right_occ[g] = cell_occ[g+1];
      end

      isort_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_value   (item.value),
        .left_value  (lv),
        .left_occ    (lo),
        .left_disp   (ld),
        .right_value (rv),
        .right_occ   (right_occ[g]),
        .value       (cell_value[g]),
        .occ         (cell_occ[g]),
        .disp        (cell_disp[g])
      );
    end
  endgenerate

  assign full       = cell_occ[MAX_ITEMS-1];
  assign item_stall = (state == ST_DRAIN);
  assign take_item  = item_valid && !item_stall;

  assign result_valid        = (state == ST_DRAIN) && cell_occ[0];
  assign result.sorted_value = cell_value[0];
  assign result.last_out     = !right_occ[0];
  assign result.overflow     = dropped;

  assign ctl.insert = take_item && !full;
  assign ctl.shift  = result_valid && !result_stall;
  assign drain_done = ctl.shift && result.last_out;

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    case (state)
      ST_LOAD: begin
        if (take_item && full) begin
          dropped_next = 1'b1;
        end
        if (take_item && item.is_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_next   = ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

endmodule

// ===== hdl/isort_checker.sv =====
// ----------------------------------------------------------------------------
// isort_checker
// port-level checks of the insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
`include "insertion_sorter_defines.svh"

module isort_checker
  import isort_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input isort_in_t  item,
  input logic       result_valid,
  input logic       result_stall,
  input isort_out_t result
);

  logic item_take;
  logic result_take;

  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // a block always yields at least one result
  `ISORT_ASSERT_NEXT(a_last_starts_drain, item_take && item.is_last, result_valid)

  // no value is taken while results are being handed out
  `ISORT_ASSERT_IMPL(a_no_load_in_drain, result_valid, item_stall)

  // a taken result that is not final is followed by another one
  `ISORT_ASSERT_NEXT(a_drain_continues, result_take && !result.last_out, result_valid)

  // after the final result the sorter takes values again
  `ISORT_ASSERT_NEXT(a_reload_after_final, result_take && result.last_out, !item_stall && !result_valid)

  // a stalled transaction holds
  `ISORT_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

// ===== test/insertion_sorter_test.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_test
// self-checking bench for the insertion sorter: directed corner blocks, then
// random blocks under changing idle mixes on both channels, every result
// checked field by field against a predicted stable ascending order
// ----------------------------------------------------------------------------
module insertion_sorter_test;
  import isort_pkg::*;

  localparam int CAPACITY = MAX_ITEMS_DEF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  class sort_scoreboard;
    logic signed [VALUE_W-1:0] held[$];
    logic dropped;
    isort_out_t awaited[$];
    int errors;

    function new();
      dropped = 1'b0;
      errors = 0;
    endfunction

    // place the value before the first strictly greater entry, emit on last
    function void note_item(isort_in_t it);
      int pos;
      bit found;
      isort_out_t r;
      pos = held.size();
      found = 1'b0;
      if (held.size() >= CAPACITY) begin
        dropped = 1'b1;
      end else begin
        for (int i = 0; i < held.size(); i++) begin
          if (!found && ($signed(held[i]) > $signed(it.value))) begin
            pos = i;
            found = 1'b1;
          end
        end
        held.insert(pos, it.value);
      end
      if (it.is_last) begin
        for (int k = 0; k < held.size(); k++) begin
          r.sorted_value = held[k];
          r.last_out = (k == held.size() - 1);
          r.overflow = dropped;
          awaited.push_back(r);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(isort_out_t got);
      isort_out_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
               got.sorted_value, got.last_out, got.overflow);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $error("sorted_value: expected %0d, actual %0d", want.sorted_value, got.sorted_value);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  isort_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  isort_out_t result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int sent = 0;

  sort_scoreboard sb = new();

  insertion_sorter #(.MAX_ITEMS(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one process notes inputs before checking results, so same-edge order is fixed
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        sb.note_item(item);
      end
      if (result_valid && !result_stall) begin
        sb.check_result(result);
      end
    end
  end

  // result side: a long hold-off when requested, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #(8 * 200000);
    $display("insertion_sorter_test: errors");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic signed [VALUE_W-1:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{value: v, is_last: last};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return $signed($urandom_range(8)) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(int len);
    for (int i = 0; i < len; i++) begin
      send_item(pick_value(), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_blocks(int target);
    int len;
    int stop_at;
    stop_at = sent + target;
    while (sent < stop_at) begin
      case ($urandom_range(9))
        0: len = $urandom_range(CAPACITY + 4, CAPACITY + 1);
        1: len = CAPACITY;
        default: len = $urandom_range(8, 1);
      endcase
      send_block(len);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 45;

    // single-value blocks at both extremes
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    // short block, extremes, zero and its lower neighbor
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b1);
    // full store with duplicates, then the last value is dropped
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: send_item(VAL_MAX - i, 1'b0);
        1: send_item(7, 1'b0);
        2: send_item(VAL_MIN + i, 1'b0);
        default: send_item(-i, 1'b0);
      endcase
    end
    send_item(1, 1'b1);
    wait_drained();

    random_blocks(40);
    wait_drained();

    send_idle_pct = 45;
    recv_idle_pct = 11;
    random_blocks(40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // hold the result side so the next block backs up against the input
    hold_left = 90;
    send_block(CAPACITY + 2);
    send_block(5);
    wait_drained();
    random_blocks(30);

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("insertion_sorter_test: clean");
    end else begin
      $display("insertion_sorter_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/isort_pkg.sv
hdl/isort_cell.sv
hdl/insertion_sorter.sv
hdl/isort_checker.sv
test/insertion_sorter_test.sv
